### hw/rtl/marching_squares_cell_contour_assert.svh
// Assertion macros for the marching squares cell contour block.
`ifndef MARCHING_SQUARES_CELL_CONTOUR_ASSERT_SVH
`define MARCHING_SQUARES_CELL_CONTOUR_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define MSQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition holds in every cycle in which a word is offered.
`define MSQ_ASSERT_WHEN_VALID(lbl, cond, msg) \
	`MSQ_ASSERT(lbl, m_tvalid |-> (cond), msg)

`endif

### hw/rtl/msq_pkg.sv
// Shared types, constants and the segment table of the marching squares block.
package msq_pkg;

	localparam int unsigned FVAL_W = 32;
	localparam int unsigned SIZE_W = 23;
	localparam int unsigned COORD_W = 24;
	localparam int unsigned CODE_W = 4;
	localparam int unsigned PROD_W = FVAL_W + SIZE_W;
	localparam int unsigned DIV_STEPS = SIZE_W;
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned IN_W = 4 * FVAL_W + 2 * COORD_W;
	localparam int unsigned OUT_W = 4 * COORD_W;

	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_CELL_WIDTH = 2'd1;
	localparam logic [1:0] REG_CELL_HEIGHT = 2'd2;

	localparam logic [FVAL_W-1:0] THRESHOLD_RST = 32'd13107;
	localparam logic [SIZE_W-1:0] CELL_SIZE_RST = 23'd3277;

	localparam logic [1:0] CORNER_LL = 2'd0;
	localparam logic [1:0] CORNER_LR = 2'd1;
	localparam logic [1:0] CORNER_UR = 2'd2;
	localparam logic [1:0] CORNER_UL = 2'd3;

	localparam logic [CODE_W-1:0] CODE_EMPTY = 4'd0;
	localparam logic [CODE_W-1:0] CODE_FULL = 4'd15;
	localparam logic [CODE_W-1:0] CODE_SADDLE_A = 4'd5;
	localparam logic [CODE_W-1:0] CODE_SADDLE_B = 4'd10;

	// One endpoint job: the moving axis gets mov +/- num * size / den.
	typedef struct packed {
		logic [FVAL_W-1:0] num;
		logic [FVAL_W-1:0] den;
		logic [SIZE_W-1:0] size;
		logic neg;
		logic axis_y;
		logic signed [COORD_W:0] mov;
		logic signed [COORD_W:0] fix;
	} msq_end_t;

	typedef struct packed {
		msq_end_t p0;
		msq_end_t p1;
		logic [CODE_W-1:0] code;
		logic last;
	} msq_job_t;

	// Edge corners of a segment: {start above, start below, end above, end below}.
	function automatic logic [7:0] seg_edges(logic [CODE_W-1:0] code, logic seg);
		logic [7:0] e;
		e = '0;
		case (code)
			4'd1: e = {CORNER_UL, CORNER_LL, CORNER_UL, CORNER_UR};
			4'd2: e = {CORNER_UR, CORNER_LR, CORNER_UR, CORNER_UL};
			4'd3: e = {CORNER_UL, CORNER_LL, CORNER_UR, CORNER_LR};
			4'd4: e = {CORNER_LR, CORNER_LL, CORNER_LR, CORNER_UR};
			4'd5: e = seg ? {CORNER_LR, CORNER_UR, CORNER_UL, CORNER_UR}
			              : {CORNER_LR, CORNER_LL, CORNER_UL, CORNER_LL};
			4'd6: e = {CORNER_LR, CORNER_LL, CORNER_UR, CORNER_UL};
			4'd7: e = {CORNER_LR, CORNER_LL, CORNER_UL, CORNER_LL};
			4'd8: e = {CORNER_LL, CORNER_LR, CORNER_LL, CORNER_UL};
			4'd9: e = {CORNER_LL, CORNER_LR, CORNER_UL, CORNER_UR};
			4'd10: e = seg ? {CORNER_UR, CORNER_UL, CORNER_LL, CORNER_UL}
			               : {CORNER_LL, CORNER_LR, CORNER_UR, CORNER_LR};
			4'd11: e = {CORNER_LL, CORNER_LR, CORNER_UR, CORNER_LR};
			4'd12: e = {CORNER_LL, CORNER_UL, CORNER_LR, CORNER_UR};
			4'd13: e = {CORNER_LR, CORNER_UR, CORNER_UL, CORNER_UR};
			4'd14: e = {CORNER_LL, CORNER_UL, CORNER_UR, CORNER_UL};
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

### hw/rtl/msq_front.sv
// Front end: holds, classifies a cell; issues a job per cycle unless job_full.
module msq_front (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [msq_pkg::IN_W-1:0] s_tdata,
	input  logic [msq_pkg::FVAL_W-1:0] threshold,
	input  logic [msq_pkg::SIZE_W-1:0] cell_width,
	input  logic [msq_pkg::SIZE_W-1:0] cell_height,
	output logic job_valid,
	output msq_pkg::msq_job_t job,
	input  logic job_full
);
	import msq_pkg::*;

	logic [FVAL_W-1:0] fv_q [4];
	logic signed [COORD_W-1:0] x0_q;
	logic signed [COORD_W-1:0] y0_q;
	logic [CODE_W-1:0] code_q;
	logic hold_q;
	logic seg_q;
	logic [CODE_W-1:0] code_in;
	logic empty_cell;
	logic saddle;
	logic last_seg;
	logic done;
	logic [7:0] edges;

	function automatic msq_end_t make_end(logic [1:0] a, logic [1:0] b,
		logic [FVAL_W-1:0] fa, logic [FVAL_W-1:0] fb, logic [FVAL_W-1:0] thr,
		logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
		logic signed [COORD_W-1:0] x0, logic signed [COORD_W-1:0] y0);
		msq_end_t e;
		logic xa, xb, ya, yb;
		logic signed [COORD_W:0] bx, by;
		xa = (a == CORNER_LR) || (a == CORNER_UR);
		xb = (b == CORNER_LR) || (b == CORNER_UR);
		ya = (a == CORNER_UR) || (a == CORNER_UL);
		yb = (b == CORNER_UR) || (b == CORNER_UL);
		bx = {x0[COORD_W-1], x0} + (xb ? {2'b00, w} : '0);
		by = {y0[COORD_W-1], y0} + (yb ? {2'b00, h} : '0);
		e.num = thr - fb;
		e.den = fa - fb;
		e.axis_y = (xa == xb);
		e.size = e.axis_y ? h : w;
		e.neg = e.axis_y ? !ya : !xa;
		e.mov = e.axis_y ? by : bx;
		e.fix = e.axis_y ? bx : by;
		return e;
	endfunction

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			code_in[3-i] = s_tdata[i*FVAL_W +: FVAL_W] >= threshold;
		end
	end

	assign empty_cell = (code_q == CODE_EMPTY) || (code_q == CODE_FULL);
	assign saddle = (code_q == CODE_SADDLE_A) || (code_q == CODE_SADDLE_B);
	assign last_seg = seg_q || !saddle;
	assign job_valid = hold_q && !empty_cell;
	assign done = hold_q && (empty_cell || (!job_full && last_seg));
	assign s_tready = !hold_q || done;
	assign edges = seg_edges(code_q, seg_q);

	always_comb begin
		job.p0 = make_end(edges[7:6], edges[5:4], fv_q[edges[7:6]], fv_q[edges[5:4]],
			threshold, cell_width, cell_height, x0_q, y0_q);
		job.p1 = make_end(edges[3:2], edges[1:0], fv_q[edges[3:2]], fv_q[edges[1:0]],
			threshold, cell_width, cell_height, x0_q, y0_q);
		job.code = code_q;
		job.last = last_seg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			seg_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				hold_q <= 1'b1;
				seg_q <= 1'b0;
			end else if (done) begin
				hold_q <= 1'b0;
			end else if (job_valid && !job_full) begin
				seg_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			for (int i = 0; i < 4; i++) begin
				fv_q[i] <= s_tdata[i*FVAL_W +: FVAL_W];
			end
			x0_q <= s_tdata[4*FVAL_W +: COORD_W];
			y0_q <= s_tdata[4*FVAL_W+COORD_W +: COORD_W];
			code_q <= code_in;
		end
	end

endmodule

### hw/rtl/msq_queue.sv
// Short job queue between the front end and the arithmetic back end.
module msq_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  msq_pkg::msq_job_t push_data,
	output logic full,
	input  logic pop,
	output logic pop_valid,
	output msq_pkg::msq_job_t pop_data
);
	import msq_pkg::*;

	msq_job_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_data = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

endmodule

### hw/rtl/msq_back.sv
// Back end: multiply, pipelined restoring divide and saturation, two lanes.
module msq_back (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  msq_pkg::msq_job_t job,
	output logic job_pop,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [msq_pkg::OUT_W-1:0] m_tdata,
	output logic [msq_pkg::CODE_W-1:0] m_tuser,
	output logic m_tlast
);
	import msq_pkg::*;

	typedef struct packed {
		logic [PROD_W-1:0] w;
		logic [FVAL_W-1:0] den;
		logic neg;
		logic axis_y;
		logic signed [COORD_W:0] mov;
		logic signed [COORD_W:0] fix;
	} msq_div_t;

	msq_div_t l0_s [DIV_STEPS+1];
	msq_div_t l1_s [DIV_STEPS+1];
	logic [CODE_W-1:0] code_s [DIV_STEPS+1];
	logic last_s [DIV_STEPS+1];
	logic [DIV_STEPS:0] vld_s;
	logic adv;
	logic [2*COORD_W-1:0] pt0;
	logic [2*COORD_W-1:0] pt1;

	function automatic msq_div_t load(msq_end_t e);
		msq_div_t d;
		d.w = e.num * e.size;
		d.den = e.den;
		d.neg = e.neg;
		d.axis_y = e.axis_y;
		d.mov = e.mov;
		d.fix = e.fix;
		return d;
	endfunction

	// One quotient bit: the remainder sits above the remaining dividend bits.
	function automatic msq_div_t step(msq_div_t d);
		msq_div_t n;
		logic [FVAL_W:0] t;
		logic ge;
		n = d;
		t = d.w[PROD_W-1:DIV_STEPS-1];
		ge = t >= {1'b0, d.den};
		if (ge) t = t - {1'b0, d.den};
		n.w = {t[FVAL_W-1:0], d.w[DIV_STEPS-2:0], ge};
		return n;
	endfunction

	function automatic logic [COORD_W-1:0] sat(logic signed [COORD_W+1:0] v);
		logic signed [COORD_W+1:0] hi, lo;
		hi = (COORD_W+2)'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
		lo = ~hi;
		if (v > hi) return hi[COORD_W-1:0];
		if (v < lo) return lo[COORD_W-1:0];
		return v[COORD_W-1:0];
	endfunction

	function automatic logic [2*COORD_W-1:0] finish(msq_div_t d);
		logic [COORD_W+1:0] q;
		logic signed [COORD_W+1:0] mv, fx;
		logic [COORD_W-1:0] a, b;
		q = {3'b000, d.w[DIV_STEPS-1:0]};
		mv = {d.mov[COORD_W], d.mov} + (d.neg ? -q : q);
		fx = {d.fix[COORD_W], d.fix};
		a = sat(mv);
		b = sat(fx);
		return d.axis_y ? {a, b} : {b, a};
	endfunction

	assign adv = !m_tvalid || m_tready;
	assign job_pop = adv && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[DIV_STEPS-1:0], job_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l0_s[0] <= load(job.p0);
			l1_s[0] <= load(job.p1);
			code_s[0] <= job.code;
			last_s[0] <= job.last;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv) begin
				l0_s[k+1] <= step(l0_s[k]);
				l1_s[k+1] <= step(l1_s[k]);
				code_s[k+1] <= code_s[k];
				last_s[k+1] <= last_s[k];
			end
		end
	end

	assign pt0 = finish(l0_s[DIV_STEPS]);
	assign pt1 = finish(l1_s[DIV_STEPS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= vld_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {pt1, pt0};
			m_tuser <= code_s[DIV_STEPS];
			m_tlast <= last_s[DIV_STEPS];
		end
	end

endmodule

### hw/rtl/marching_squares_cell_contour.sv
// Top level of the marching squares cell contour block.
// A cell enters on the s_ channel as one word: four corner field values and
// the world position of its lower-left corner. Each contour segment leaves on
// the m_ channel as one word with both endpoints; tuser carries the cell's
// case code and tlast marks the last segment of the cell. Empty and full
// cells give no word; saddle cells give two.
// While the queue has room, the front end takes one cell per cycle for cells
// with at most one segment and issues one segment job per cycle; a saddle cell
// is held until both of its jobs are issued. After an input word is accepted,
// its first segment word passes through the job queue, the multiply stage, 23
// divide stages (one quotient bit each) and the output register to reach m_.
// The user must write registers via cfg_we/cfg_addr/cfg_wdata only while idle;
// the block does not enforce it. Reset loads threshold 0.2, cell sizes 0.05
// and empties all stages. When the receiver stalls, the back pipeline holds;
// the four-entry queue and front hold register keep taking words until full.
module marching_squares_cell_contour (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// value_lower_left, value_lower_right, value_upper_right, value_upper_left,
	// origin_x, origin_y
	input  logic [msq_pkg::IN_W-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// start_x, start_y, end_x, end_y
	output logic [msq_pkg::OUT_W-1:0] m_tdata,
	// case_code
	output logic [msq_pkg::CODE_W-1:0] m_tuser,
	output logic m_tlast,
	input  logic cfg_we,
	input  logic [1:0] cfg_addr,
	input  logic [msq_pkg::FVAL_W-1:0] cfg_wdata
);
	import msq_pkg::*;

	logic [FVAL_W-1:0] threshold_q;
	logic [SIZE_W-1:0] cell_width_q;
	logic [SIZE_W-1:0] cell_height_q;
	logic push;
	msq_job_t push_job;
	logic q_full;
	logic pop;
	logic pop_valid;
	msq_job_t pop_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			cell_width_q <= CELL_SIZE_RST;
			cell_height_q <= CELL_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_THRESHOLD: threshold_q <= cfg_wdata;
				REG_CELL_WIDTH: cell_width_q <= cfg_wdata[SIZE_W-1:0];
				REG_CELL_HEIGHT: cell_height_q <= cfg_wdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	msq_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.threshold(threshold_q),
		.cell_width(cell_width_q),
		.cell_height(cell_height_q),
		.job_valid(push),
		.job(push_job),
		.job_full(q_full)
	);

	msq_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_job),
		.full(q_full),
		.pop(pop),
		.pop_valid(pop_valid),
		.pop_data(pop_job)
	);

	msq_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(pop_valid),
		.job(pop_job),
		.job_pop(pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

endmodule

### hw/rtl/msq_check.sv
// Port checker for the marching squares block and its bind.
`include "marching_squares_cell_contour_assert.svh"

module msq_check (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [msq_pkg::OUT_W-1:0] m_tdata,
	input logic [msq_pkg::CODE_W-1:0] m_tuser,
	input logic m_tlast
);
	import msq_pkg::*;

	`MSQ_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "word dropped while stalled")
	`MSQ_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "word changed while stalled")
	`MSQ_ASSERT_WHEN_VALID(a_no_empty, (m_tuser != CODE_EMPTY) && (m_tuser != CODE_FULL), "segment from empty or full cell")
	`MSQ_ASSERT_WHEN_VALID(a_first_saddle, m_tlast || (m_tuser == CODE_SADDLE_A) || (m_tuser == CODE_SADDLE_B), "non-last word outside a saddle")

endmodule

bind marching_squares_cell_contour msq_check u_msq_check (.*);

### sim/tb_top.sv
// Self-checking testbench for the marching squares cell contour block.
`timescale 1ns / 100ps

module tb_top;
	import msq_pkg::*;

	typedef struct packed {
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [COORD_W-1:0] ex;
		logic [COORD_W-1:0] ey;
		logic [CODE_W-1:0] code;
		logic last;
	} segment_t;

	typedef struct {
		logic [FVAL_W-1:0] f [4];
		logic [COORD_W-1:0] ox;
		logic [COORD_W-1:0] oy;
	} cell_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [CODE_W-1:0] m_tuser;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_addr = REG_THRESHOLD;
	logic [FVAL_W-1:0] cfg_wdata = '0;

	logic [FVAL_W-1:0] iso_level;
	logic [SIZE_W-1:0] width_q, height_q;
	segment_t expected_segments [$];
	int errors = 0;
	int hold_off = 0;
	bit stall_enable = 1'b0;

	marching_squares_cell_contour u_top (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#50ms;
		$display("** marching_squares_cell_contour: FAILED **");
		$finish;
	end

	function automatic logic [COORD_W-1:0] clamp24(longint v);
		if (v > 64'sd8388607) v = 64'sd8388607;
		if (v < -64'sd8388608) v = -64'sd8388608;
		return v[COORD_W-1:0];
	endfunction

	// Corner order in a vertex: lower left, lower right, upper right, upper left.
	function automatic void place_point(cell_t c, longint cx[4], longint cy[4], int a, int b,
			output logic [COORD_W-1:0] px, output logic [COORD_W-1:0] py);
		longint num, den, dx, dy;
		num = longint'(iso_level) - longint'(c.f[b]);
		den = longint'(c.f[a]) - longint'(c.f[b]);
		dx = 0;
		dy = 0;
		if (den > 0) begin
			dx = (num * (cx[a] - cx[b])) / den;
			dy = (num * (cy[a] - cy[b])) / den;
		end
		px = clamp24(cx[b] + dx);
		py = clamp24(cy[b] + dy);
	endfunction

	function automatic logic [15:0] edge_corners(logic [3:0] code, int seg);
		// Nibbles: start above, start below, end above, end below.
		case (code)
			4'd1: return 16'h3032;
			4'd2: return 16'h2123;
			4'd3: return 16'h3021;
			4'd4: return 16'h1012;
			4'd5: return seg ? 16'h1232 : 16'h1030;
			4'd6: return 16'h1023;
			4'd7: return 16'h1030;
			4'd8: return 16'h0103;
			4'd9: return 16'h0132;
			4'd10: return seg ? 16'h2303 : 16'h0121;
			4'd11: return 16'h0121;
			4'd12: return 16'h0312;
			4'd13: return 16'h1232;
			4'd14: return 16'h0323;
			default: return 16'h0;
		endcase
	endfunction

	function automatic void predict_segments(cell_t c);
		longint cx[4], cy[4];
		logic [3:0] code;
		logic [15:0] e;
		segment_t s;
		int n;
		code = '0;
		for (int i = 0; i < 4; i++)
			if (c.f[i] >= iso_level) code[3-i] = 1'b1;
		cx[0] = longint'(signed'(c.ox));
		cy[0] = longint'(signed'(c.oy));
		cx[1] = cx[0] + width_q;
		cy[1] = cy[0];
		cx[2] = cx[1];
		cy[2] = cy[0] + height_q;
		cx[3] = cx[0];
		cy[3] = cy[2];
		n = (code == CODE_EMPTY || code == CODE_FULL) ? 0 :
			(code == CODE_SADDLE_A || code == CODE_SADDLE_B) ? 2 : 1;
		for (int i = 0; i < n; i++) begin
			e = edge_corners(code, i);
			place_point(c, cx, cy, e[15:12], e[11:8], s.sx, s.sy);
			place_point(c, cx, cy, e[7:4], e[3:0], s.ex, s.ey);
			s.code = code;
			s.last = (i == n - 1);
			expected_segments.push_back(s);
		end
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	// Receiver: random stall pattern plus a long forced hold-off.
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= stall_enable ? ($urandom_range(0, 3) != 0) : 1'b1;
		end
	end

	always @(posedge clk) begin
		segment_t w;
		if (m_tvalid && m_tready) begin
			if (expected_segments.size() == 0) begin
				report_mismatch("unexpected word", m_tdata[23:0], 0);
			end else begin
				w = expected_segments.pop_front();
				if (m_tdata[23:0] != w.sx) report_mismatch("start_x", m_tdata[23:0], w.sx);
				if (m_tdata[47:24] != w.sy) report_mismatch("start_y", m_tdata[47:24], w.sy);
				if (m_tdata[71:48] != w.ex) report_mismatch("end_x", m_tdata[71:48], w.ex);
				if (m_tdata[95:72] != w.ey) report_mismatch("end_y", m_tdata[95:72], w.ey);
				if (m_tuser != w.code) report_mismatch("case_code", m_tuser, w.code);
				if (m_tlast != w.last) report_mismatch("last_segment", m_tlast, w.last);
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [FVAL_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_THRESHOLD: iso_level = v;
			REG_CELL_WIDTH: width_q = v[SIZE_W-1:0];
			default: height_q = v[SIZE_W-1:0];
		endcase
	endtask

	task automatic send_cell(cell_t c);
		s_tdata <= {c.oy, c.ox, c.f[3], c.f[2], c.f[1], c.f[0]};
		s_tvalid <= 1'b1;
		predict_segments(c);
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (expected_segments.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [FVAL_W-1:0] rand_value();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return iso_level + $urandom_range(0, 2) - 1;
			3: return $urandom;
			default: return iso_level + $urandom_range(0, 65535) - 32768;
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return COORD_W'(24'h7FFFFF - $urandom_range(0, 3));
			1: return COORD_W'(24'h800000 + $urandom_range(0, 3));
			default: return COORD_W'($urandom);
		endcase
	endfunction

	task automatic random_phase(int count, bit pressure);
		cell_t c;
		int burst;
		bit pressed;
		pressed = 1'b0;
		while (count > 0) begin
			burst = $urandom_range(1, 20);
			if (pressure && !pressed && count <= 120) begin
				hold_off <= 150;
				pressed = 1'b1;
			end
			for (int i = 0; i < burst && count > 0; i++) begin
				for (int k = 0; k < 4; k++) c.f[k] = rand_value();
				c.ox = rand_coord();
				c.oy = rand_coord();
				send_cell(c);
				count--;
			end
			if ($urandom_range(0, 2) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	// Directed rows: corner values, origin; one row per case plus extremes.
	logic [FVAL_W-1:0] dir_f [18][4];
	logic [COORD_W-1:0] dir_o [18][2];

	initial begin
		cell_t c;
		iso_level = THRESHOLD_RST;
		width_q = CELL_SIZE_RST;
		height_q = CELL_SIZE_RST;
		for (int code = 0; code < 16; code++) begin
			for (int k = 0; k < 4; k++)
				dir_f[code][k] = code[3-k] ? 32'd20000 + k * 1000 : 32'd100 + k * 777;
			dir_o[code][0] = COORD_W'(code * 5000);
			dir_o[code][1] = COORD_W'(-code * 3000);
		end
		dir_f[16] = '{32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h0};
		dir_o[16] = '{24'h7FFFFF, 24'h7FFFFF};
		dir_f[17] = '{32'h0, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF};
		dir_o[17] = '{24'h800000, 24'h800000};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Cell at the origin after reset: lower left alone above threshold.
		c.f = '{32'd13107, 32'd0, 32'd0, 32'd0};
		c.ox = '0;
		c.oy = '0;
		send_cell(c);
		drain();
		if (expected_segments.size() != 0) begin
			$display("** marching_squares_cell_contour: FAILED **");
			$finish;
		end

		for (int r = 0; r < 18; r++) begin
			c.f = dir_f[r];
			c.ox = dir_o[r][0];
			c.oy = dir_o[r][1];
			send_cell(c);
		end
		drain();

		write_reg(REG_CELL_WIDTH, 32'h7FFFFF);
		write_reg(REG_CELL_HEIGHT, 32'h7FFFFF);
		write_reg(REG_THRESHOLD, 32'hFFFFFFFF);
		for (int r = 0; r < 18; r++) begin
			c.f = dir_f[r];
			c.ox = dir_o[r][0];
			c.oy = dir_o[r][1];
			send_cell(c);
		end
		random_phase(20, 1'b0);
		drain();

		write_reg(REG_THRESHOLD, 32'd0);
		write_reg(REG_CELL_WIDTH, 32'd1);
		write_reg(REG_CELL_HEIGHT, 32'd0);
		random_phase(20, 1'b0);
		drain();

		write_reg(REG_THRESHOLD, 32'h00010000);
		write_reg(REG_CELL_WIDTH, 32'h10000);
		write_reg(REG_CELL_HEIGHT, 32'h8000);
		stall_enable = 1'b1;
		random_phase(250, 1'b1);
		drain();

		write_reg(REG_THRESHOLD, $urandom);
		write_reg(REG_CELL_WIDTH, $urandom_range(1, 8388607));
		write_reg(REG_CELL_HEIGHT, $urandom_range(1, 8388607));
		random_phase(120, 1'b0);
		stall_enable = 1'b0;
		random_phase(100, 1'b0);
		drain();

		if (errors == 0 && expected_segments.size() == 0) begin
			$display("** marching_squares_cell_contour: PASSED **");
		end else begin
			$display("** marching_squares_cell_contour: FAILED **");
		end
		$finish;
	end

endmodule
